/* sv/modular_exponentiation_top_macros.svh */
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MODEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MODEXP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MODEXP_ASSERT(lbl, prop, msg)
`define MODEXP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared width default and multiplier control word.
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  localparam int MODEXP_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

endpackage

`default_nettype wire

/* sv/modular_exponentiation_top.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// base^exponent mod modulus, right-to-left binary method, bit-serial products.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                  Word
// command   in   start & !busy              base, exponent
// result    out  done (one-cycle strobe)    power_result
// config    in   modulus_we                 modulus_wdata
//
// Base reduction is a restoring remainder, one base bit per cycle; each
// exponent bit runs a load, a multiplier step for each multiplier bit and an update.
// busy falls with done, so a new command may be taken in the done cycle.
// Synchronous reset sets modulus to 1; modulus of 0 means 2^WIDTH.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_exponentiation_top_macros.svh"

module modular_exponentiation_top #(
  parameter int WIDTH = modexp_pkg::MODEXP_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] base,
  input  logic [WIDTH-1:0] exponent,
  input  logic             modulus_we,
  input  logic [WIDTH-1:0] modulus_wdata,
  output logic             done,
  output logic [WIDTH-1:0] power_result
);
  import modexp_pkg::*;

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    REDUCE,
    LOAD,
    MUL,
    UPDATE
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] bsh;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] pw;
  logic [WIDTH-1:0] acc;
  logic [CW-1:0]    cnt;

  logic [WIDTH:0]   m_ext;
  logic [WIDTH:0]   r_sh;
  logic [WIDTH:0]   r_sub;
  logic [WIDTH-1:0] red_next;
  logic             cnt_last;
  mul_ctrl_t        mul_ctrl;
  logic [WIDTH-1:0] prod_acc;
  logic [WIDTH-1:0] prod_sq;

  assign m_ext    = {~|modulus, modulus};
  assign r_sh     = {pw, bsh[WIDTH-1]};
  assign r_sub    = r_sh - m_ext;
  assign red_next = (r_sh >= m_ext) ? r_sub[WIDTH-1:0] : r_sh[WIDTH-1:0];
  assign cnt_last = (cnt == CW'(WIDTH - 1));
  assign busy     = (state != IDLE);

  always_comb begin
    mul_ctrl.load = (state == LOAD);
    mul_ctrl.step = (state == MUL);
  end

  modexp_mul #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk     (clk),
    .ctrl    (mul_ctrl),
    .m_ext   (m_ext),
    .acc_in  (acc),
    .pw_in   (pw),
    .prod_acc(prod_acc),
    .prod_sq (prod_sq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      done    <= 1'b0;
      modulus <= WIDTH'(1);
    end else begin
      done <= 1'b0;
      if (modulus_we) begin
        modulus <= modulus_wdata;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            bsh   <= base;
            e     <= exponent;
            pw    <= '0;
            acc   <= WIDTH'(1);
            cnt   <= '0;
            state <= REDUCE;
          end
        end
        REDUCE: begin
          pw  <= red_next;
          bsh <= bsh << 1;
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            cnt <= '0;
            if (e == '0) begin
              done         <= 1'b1;
              power_result <= acc;
              state        <= IDLE;
            end else begin
              state <= LOAD;
            end
          end
        end
        LOAD: begin
          cnt   <= '0;
          state <= MUL;
        end
        MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt_last) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (e[0]) begin
            acc <= prod_acc;
          end
          pw <= prod_sq;
          e  <= e >> 1;
          if (e[WIDTH-1:1] == '0) begin
            done         <= 1'b1;
            power_result <= e[0] ? prod_acc : acc;
            state        <= IDLE;
          end else begin
            state <= LOAD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `MODEXP_ASSERT(a_done_idle, done |-> !busy, "result strobe while busy")
  `MODEXP_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `MODEXP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `MODEXP_ASSERT_ALWAYS(a_rst_clear, rst |=> (!busy && !done), "reset left block active")

endmodule

`default_nettype wire

/* sv/modexp_mul.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation dual multiplier
// Bit-serial shift-and-add modular multiply; forms acc*pw and pw*pw together,
// one multiplier bit per cycle while step is asserted.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mul #(
  parameter int WIDTH = modexp_pkg::MODEXP_WIDTH_DEF
) (
  input  logic                  clk,
  input  modexp_pkg::mul_ctrl_t ctrl,
  input  logic [WIDTH:0]        m_ext,
  input  logic [WIDTH-1:0]      acc_in,
  input  logic [WIDTH-1:0]      pw_in,
  output logic [WIDTH-1:0]      prod_acc,
  output logic [WIDTH-1:0]      prod_sq
);
  import modexp_pkg::*;

  // (x + y) mod m for x, y < m; m_ext of 2^WIDTH gives plain wrap
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH:0]   m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= m) begin
      s = s - m;
    end
    return s[WIDTH-1:0];
  endfunction

  logic [WIDTH-1:0] mplier;
  logic [WIDTH-1:0] addend_a;
  logic [WIDTH-1:0] addend_p;
  logic [WIDTH-1:0] sum_a;
  logic [WIDTH-1:0] sum_p;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mplier   <= pw_in;
      addend_a <= acc_in;
      addend_p <= pw_in;
      sum_a    <= '0;
      sum_p    <= '0;
    end else if (ctrl.step) begin
      if (mplier[0]) begin
        sum_a <= add_mod(sum_a, addend_a, m_ext);
        sum_p <= add_mod(sum_p, addend_p, m_ext);
      end
      addend_a <= add_mod(addend_a, addend_a, m_ext);
      addend_p <= add_mod(addend_p, addend_p, m_ext);
      mplier   <= mplier >> 1;
    end
  end

  assign prod_acc = sum_a;
  assign prod_sq  = sum_p;

endmodule

`default_nettype wire

/* sim/modexp_checker.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation result checker
// Tracks the modulus register, predicts base^exponent mod modulus for every
// accepted command word and compares each done word against the oldest
// prediction. Reports the error count and the number of words still owed.
// ----------------------------------------------------------------------------
module modexp_checker #(
  parameter int WIDTH = modexp_pkg::MODEXP_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [WIDTH-1:0] base,
  input  logic [WIDTH-1:0] exponent,
  input  logic             modulus_we,
  input  logic [WIDTH-1:0] modulus_wdata,
  input  logic             done,
  input  logic [WIDTH-1:0] power_result,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] power;
  } power_word_t;

  power_word_t      expected_powers[$];
  power_word_t      oldest;
  logic [WIDTH-1:0] modulus_copy = 1;
  int               mismatch_count = 0;
  int               owed_count = 0;

  assign errors  = mismatch_count;
  assign pending = owed_count;

  // modulus of zero stands for 2^WIDTH: plain wrap
  function automatic logic [WIDTH-1:0] mul_reduce(input logic [WIDTH-1:0] a, b, m);
    logic [2*WIDTH-1:0] prod;
    prod = a * b;
    if (m == 0) begin
      return prod[WIDTH-1:0];
    end
    prod = prod % m;
    return prod[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] mod_power(input logic [WIDTH-1:0] b, e, m);
    logic [WIDTH-1:0] acc;
    logic [WIDTH-1:0] sq;
    acc = 1;
    sq  = (m == 0) ? b : b % m;
    for (int i = 0; i < WIDTH; i++) begin
      if (e[i]) begin
        acc = mul_reduce(acc, sq, m);
      end
      sq = mul_reduce(sq, sq, m);
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      modulus_copy = 1;
      expected_powers.delete();
    end else begin
      if (done) begin
        if (expected_powers.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h",
                   $time, power_result);
          mismatch_count++;
        end else begin
          oldest = expected_powers.pop_front();
          if (power_result !== oldest.power) begin
            $display("%0t: power_result mismatch: expected %h, actual %h (base %h exp %h mod %h)",
                     $time, oldest.power, power_result, oldest.base, oldest.exponent,
                     oldest.modulus);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_powers.push_back('{base, exponent, modulus_copy,
                                   mod_power(base, exponent, modulus_copy)});
      end
      if (modulus_we) begin
        modulus_copy = modulus_wdata;
      end
    end
    owed_count = expected_powers.size();
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives command words and modulus writes over a series of modulus settings:
// some phases open with directed corner words, then every phase sends random
// words, with random sender gaps and one stretch with none. Results are
// checked by modexp_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH = modexp_pkg::MODEXP_WIDTH_DEF;
  localparam logic [WIDTH-1:0] ALL_ONES = '1;
  localparam logic [WIDTH-1:0] PRIME    = 32'hFFFF_FFFB;
  localparam int RANDOM_PER_PHASE = 54;
  localparam int PHASES           = 10;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [WIDTH-1:0] base = '0;
  logic [WIDTH-1:0] exponent = '0;
  logic             modulus_we = 1'b0;
  logic [WIDTH-1:0] modulus_wdata = '0;
  logic             done;
  logic [WIDTH-1:0] power_result;
  int               errors;
  int               pending;
  logic [WIDTH-1:0] modulus_now = 1;

  modular_exponentiation_top #(.WIDTH(WIDTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .exponent     (exponent),
    .modulus_we   (modulus_we),
    .modulus_wdata(modulus_wdata),
    .done         (done),
    .power_result (power_result)
  );

  modexp_checker #(.WIDTH(WIDTH)) power_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .exponent     (exponent),
    .modulus_we   (modulus_we),
    .modulus_wdata(modulus_wdata),
    .done         (done),
    .power_result (power_result),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [WIDTH-1:0] b, e, input bit may_idle);
    if (may_idle && $urandom_range(99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 300)) @(negedge clk);
    end
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_modulus(input logic [WIDTH-1:0] m);
    wait_drained();
    repeat (4) @(negedge clk);
    modulus_we    <= 1'b1;
    modulus_wdata <= m;
    modulus_now    = m;
    @(negedge clk);
    modulus_we <= 1'b0;
  endtask

  function automatic logic [WIDTH-1:0] rand_base(input logic [WIDTH-1:0] m);
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return m - 1;
      3:       return m;
      4:       return m + $urandom_range(1, 3);
      5:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] rand_exponent();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom_range(1, 3);
      2:       return ALL_ONES;
      3, 4:    return $urandom_range(0, 255);
      5, 6:    return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] pick_modulus(input int phase);
    case (phase)
      1:       return ALL_ONES;
      2:       return 2;
      3:       return PRIME;
      4:       return 32'h8000_0000;
      5:       return $urandom_range(1, 1000);
      6:       return $urandom_range(32'hFFFF_FFFF, 1);
      7:       return 1;
      8:       return $urandom_range(1, 32'hFFFF);
      default: return $urandom_range(32'hFFFF_FFFF, 1);
    endcase
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        write_modulus(pick_modulus(p));
      end
      case (p)
        0: begin
          send_word(5, 0, 1'b0);
          send_word(5, 1, 1'b0);
          send_word(ALL_ONES, ALL_ONES, 1'b0);
          send_word(0, 0, 1'b0);
          send_word(0, 1, 1'b0);
        end
        1: begin
          send_word(0, 0, 1'b0);
          send_word(0, 5, 1'b0);
          send_word(ALL_ONES, 1, 1'b0);
          send_word(ALL_ONES - 1, 2, 1'b0);
          send_word(ALL_ONES, ALL_ONES, 1'b0);
          send_word(2, 31, 1'b0);
          send_word(2, 32, 1'b0);
          send_word(3, ALL_ONES, 1'b0);
          send_word(1, ALL_ONES, 1'b0);
          send_word(ALL_ONES - 1, ALL_ONES, 1'b0);
          send_word(32'h8000_0000, 32'h8000_0000, 1'b0);
          send_word(12345, 1, 1'b0);
        end
        3: begin
          send_word(2, PRIME - 1, 1'b0);
          send_word(PRIME, 3, 1'b0);
          send_word(PRIME + 1, ALL_ONES, 1'b0);
          send_word(PRIME - 1, 2, 1'b0);
          send_word(7, ALL_ONES, 1'b0);
        end
        default: ;
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if ((p == 5 && i == RANDOM_PER_PHASE / 2) || $urandom_range(99) < 3) begin
          wait_drained();
        end
        // phase 3 runs back to back with no sender gaps
        send_word(rand_base(modulus_now), rand_exponent(), p != 3);
      end
    end

    wait_drained();
    repeat (1200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
